// ===== rtl/grr_pkg.sv =====
package grr_pkg;

  localparam int PIX_W           = 32;
  localparam int COL_W           = 4;
  localparam int CNT_W           = 5;
  localparam int SHIFT_W         = 16;
  localparam int CELL_ROWS       = 16;
  localparam int MAX_GLYPH_WIDTH = 16;
  localparam int NARROW_LIMIT    = 8;
  localparam int CURSOR_ROW      = 14;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [1:0] HL_NONE   = 2'd0;
  localparam logic [1:0] HL_CURSOR = 2'd1;
  localparam logic [1:0] HL_CELL   = 2'd2;

  localparam cnt_t NARROW_LIMIT_C = cnt_t'(NARROW_LIMIT);
  localparam cnt_t MAX_WIDTH_C    = cnt_t'(MAX_GLYPH_WIDTH);
  localparam logic [3:0] CURSOR_ROW_C = 4'(CURSOR_ROW);

endpackage

// ===== rtl/glyph_row_rasterizer.sv =====
// Glyph row rasterizer: takes one row item (32-bit glyph word, row number,
// glyph width, clip width, colour, highlight mode) and streams min(width,
// clip, 16) pixels out, column 0 first, the final one flagged with out_last.
// The selected row is loaded into a 16-bit shift register and one pixel
// leaves it per cycle while out_ready stays high or the output register is
// empty; the input stays closed until every pixel of the row has left
// the shift register; a row with no pixels does not close it. The next
// row item is taken in the cycle after the last pixel has moved into the
// output register, while that pixel may still be waiting for out_ready.
module glyph_row_rasterizer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [31:0]                  in_row_bits,
  input  logic [3:0]                   in_row,
  input  logic [4:0]                   in_glyph_width,
  input  logic [4:0]                   in_width_left,
  input  logic [31:0]                  in_color,
  input  logic [1:0]                   in_highlight,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [grr_pkg::PIX_W-1:0]    out_pixel_value,
  output logic [grr_pkg::COL_W-1:0]    out_column,
  output logic                         out_last
);
  import grr_pkg::*;

  logic [SHIFT_W-1:0] row_shift_r, row_shift_nxt;
  cnt_t               pixels_left_r, pixels_left_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  pix_t               fore_value_r, fore_value_nxt;
  pix_t               back_value_r, back_value_nxt;
  logic               out_valid_r, out_valid_nxt;
  pix_t               out_pixel_value_r, out_pixel_value_nxt;
  logic [COL_W-1:0]   out_column_r, out_column_nxt;
  logic               out_last_r, out_last_nxt;

  logic               busy;
  logic               in_acc;
  logic               out_load;
  logic               wide;
  logic               inv;
  cnt_t               n_min;
  cnt_t               n_pix;
  logic [SHIFT_W-1:0] sel_row;

  assign busy     = (pixels_left_r != '0);
  assign in_ready = !busy;
  assign in_acc   = in_valid && in_ready;
  assign out_load = busy && (!out_valid_r || out_ready);

  always_comb begin
    wide  = (in_glyph_width > NARROW_LIMIT_C);
    n_min = (in_glyph_width < in_width_left) ? in_glyph_width : in_width_left;
    n_pix = (n_min > MAX_WIDTH_C) ? MAX_WIDTH_C : n_min;
    case (in_highlight)
      HL_CURSOR: inv = (in_row >= CURSOR_ROW_C);
      HL_CELL:   inv = 1'b1;
      default:   inv = 1'b0;
    endcase
    if (wide) begin
      sel_row = in_row[0] ? in_row_bits[15:0] : in_row_bits[31:16];
    end else begin
      case (in_row[1:0])
        2'd0:    sel_row = {in_row_bits[31:24], 8'h00};
        2'd1:    sel_row = {in_row_bits[23:16], 8'h00};
        2'd2:    sel_row = {in_row_bits[15:8], 8'h00};
        default: sel_row = {in_row_bits[7:0], 8'h00};
      endcase
    end
  end

  always_comb begin
    row_shift_nxt       = row_shift_r;
    pixels_left_nxt     = pixels_left_r;
    col_nxt             = col_r;
    fore_value_nxt      = fore_value_r;
    back_value_nxt      = back_value_r;
    out_pixel_value_nxt = out_pixel_value_r;
    out_column_nxt      = out_column_r;
    out_last_nxt        = out_last_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt       = 1'b1;
      out_pixel_value_nxt = row_shift_r[SHIFT_W-1] ? fore_value_r : back_value_r;
      out_column_nxt      = col_r;
      out_last_nxt        = (pixels_left_r == cnt_t'(1));
      row_shift_nxt       = {row_shift_r[SHIFT_W-2:0], 1'b0};
      col_nxt             = col_r + COL_W'(1);
      pixels_left_nxt     = pixels_left_r - cnt_t'(1);
    end
    if (in_acc && (n_pix != '0)) begin
      row_shift_nxt   = sel_row;
      pixels_left_nxt = n_pix;
      col_nxt         = '0;
      fore_value_nxt  = inv ? '0 : in_color;
      back_value_nxt  = inv ? in_color : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_left_r <= '0;
      out_valid_r   <= 1'b0;
      row_shift_r   <= '0;
      col_r         <= '0;
      fore_value_r  <= '0;
      back_value_r  <= '0;
    end else begin
      pixels_left_r <= pixels_left_nxt;
      out_valid_r   <= out_valid_nxt;
      row_shift_r   <= row_shift_nxt;
      col_r         <= col_nxt;
      fore_value_r  <= fore_value_nxt;
      back_value_r  <= back_value_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_value_r <= out_pixel_value_nxt;
    out_column_r      <= out_column_nxt;
    out_last_r        <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pixel_value_r;
  assign out_column      = out_column_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/grr_checker.sv =====
module grr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [4:0]                in_glyph_width,
  input logic [4:0]                in_width_left,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [grr_pkg::PIX_W-1:0] out_pixel_value,
  input logic [grr_pkg::COL_W-1:0] out_column,
  input logic                      out_last
);
  import grr_pkg::*;

  // a row with pixels to send blocks the input
  a_busy_after_row: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_glyph_width != 5'd0 && in_width_left != 5'd0)
    |=> !in_ready)
    else $error("input taken while a row is in flight");

  // pixels of a row follow each other with rising column
  a_next_column: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last)
    |=> (out_valid && out_column == $past(out_column) + COL_W'(1)))
    else $error("row word missing or out of order");

  a_no_input_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> !in_ready)
    else $error("input ready before row is finished");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready)
    |=> (out_valid && $stable(out_pixel_value) && $stable(out_column)
         && $stable(out_last)))
    else $error("stalled output word changed");

endmodule

bind glyph_row_rasterizer grr_checker u_grr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_glyph_width  (in_glyph_width),
  .in_width_left   (in_width_left),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_value (out_pixel_value),
  .out_column      (out_column),
  .out_last        (out_last)
);
